// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the evaluator top module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and helper functions of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int DATA_W          = 32;
   localparam int ACCUM_W         = 31;
   localparam int ITER_W          = 5;

   localparam logic [ACCUM_W-1:0] ACCUM_LIMIT = 31'd214748364;
   localparam logic [ITER_W-1:0]  ITER_LAST   = 5'd31;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLOSE,
      S_POP_B,
      S_POP_A,
      S_EXEC,
      S_MUL_LOOP,
      S_NEG_A,
      S_NEG_B,
      S_DIV_LOOP,
      S_DIV_FIX,
      S_WRITE,
      S_FINISH,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_OUT,
      PH_NUM,
      PH_OTHER
   } phase_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_OTHER
   } op_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_UNDER,
      ST_DIVZERO,
      ST_BIGLIT,
      ST_OVER
   } status_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic op_type op_code(input logic [7:0] c);
      op_type op;
      case (c)
         8'h2b:   op = OP_ADD;
         8'h2d:   op = OP_SUB;
         8'h2a:   op = OP_MUL;
         8'h2f:   op = OP_DIV;
         default: op = OP_OTHER;
      endcase
      return op;
   endfunction

endpackage

// File: design/postfix_expression_evaluator_top.sv
// a plain token byte is taken in S_IDLE; a space or the last byte also passes S_CLOSE to close the token
// closing + or - pops both operands and uses the shared adder once; * and / run 32 steps of it
// the last byte then reads the top of stack in S_FINISH and waits in S_EMIT on any rsp_stall
// throughput: one byte at a time, req_stall is high while the sequencer is busy
// reset: synchronous active-high; clears control state, the stack RAM keeps its contents
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// ASCII postfix evaluator: stack in RAM, one shared adder for add, sub,
// shift-add multiply and restoring divide, sequenced by a small FSM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_in_byte,
   input  logic                              req_end_of_expr,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pfe_pkg::DATA_W-1:0] rsp_value,
   output logic [2:0]                        rsp_status
);
   import pfe_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   status_type           err_ff, err_in;
   phase_type            phase_ff, phase_in;
   logic [ACCUM_W-1:0]   accum_ff, accum_in;
   logic                 ended_ff, ended_in;
   op_type               op_ff, op_in;
   logic                 last_ff, last_in;
   logic [DATA_W-1:0]    a_ff, a_in;
   logic [DATA_W-1:0]    b_ff, b_in;
   logic [DATA_W-1:0]    q_ff, q_in;
   logic [DATA_W-1:0]    res_ff, res_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0]    ram_wr_data, ram_rd_data;

   // shared adder
   logic [DATA_W:0]      add_x, add_y;
   logic                 add_cin;
   logic [DATA_W+1:0]    add_sum;

   logic                 req_xfer, out_free, byte_space, byte_digit;
   logic [3:0]           digit_val;
   logic [CW-1:0]        cnt_m1, cnt_m2;
   logic [DATA_W:0]      div_shift;
   state_type            after_op;

   pfe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign byte_space = is_space(req_in_byte);
   assign byte_digit = is_digit(req_in_byte);
   assign digit_val  = req_in_byte[3:0];
   assign cnt_m1     = cnt_ff - CW'(1);
   assign cnt_m2     = cnt_ff - CW'(2);
   assign div_shift  = {res_ff, q_ff[DATA_W-1]};
   assign after_op   = last_ff ? S_FINISH : S_IDLE;
   assign add_sum    = {1'b0, add_x} + {1'b0, add_y} + (DATA_W+2)'(add_cin);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         err_ff       <= ST_OK;
         phase_ff     <= PH_OUT;
         accum_ff     <= '0;
         ended_ff     <= 1'b0;
         op_ff        <= OP_NONE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         ended_ff     <= ended_in;
         op_ff        <= op_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      q_ff          <= q_in;
      res_ff        <= res_in;
      iter_ff       <= iter_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      phase_in      = phase_ff;
      accum_in      = accum_ff;
      ended_in      = ended_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      q_in          = q_ff;
      res_in        = res_ff;
      iter_in       = iter_ff;
      neg_in        = neg_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cnt_ff[AW-1:0];
      ram_wr_data   = res_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cnt_m1[AW-1:0];
      add_x         = {1'b0, a_ff};
      add_y         = {1'b0, b_ff};
      add_cin       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               last_in = req_end_of_expr;
               if (!byte_space && (err_ff == ST_OK)) begin
                  unique case (phase_ff)
                     PH_OUT: begin
                        if (byte_digit) begin
                           phase_in = PH_NUM;
                           accum_in = ACCUM_W'(digit_val);
                        end else begin
                           phase_in = PH_OTHER;
                           op_in    = op_code(req_in_byte);
                        end
                     end
                     PH_NUM: begin
                        if (!byte_digit) begin
                           ended_in = 1'b1;
                        end else if (!ended_ff) begin
                           if ((accum_ff > ACCUM_LIMIT) ||
                               ((accum_ff == ACCUM_LIMIT) && (digit_val > 4'd7))) begin
                              err_in = ST_BIGLIT;
                           end else begin
                              accum_in = (accum_ff << 3) + (accum_ff << 1)
                                         + ACCUM_W'(digit_val);
                           end
                        end
                     end
                     default: begin
                        op_in = OP_OTHER;
                     end
                  endcase
               end
               if (byte_space || req_end_of_expr) begin
                  state_in = S_CLOSE;
               end
            end
         end

         S_CLOSE: begin
            phase_in = PH_OUT;
            accum_in = '0;
            ended_in = 1'b0;
            op_in    = OP_NONE;
            state_in = after_op;
            if (err_ff == ST_OK) begin
               if (phase_ff == PH_NUM) begin
                  if (cnt_ff == CW'(STACK_DEPTH)) begin
                     err_in = ST_OVER;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {1'b0, accum_ff};
                     cnt_in      = cnt_ff + CW'(1);
                  end
               end else if (phase_ff == PH_OTHER) begin
                  if (cnt_ff < CW'(2)) begin
                     err_in = ST_UNDER;
                  end else begin
                     op_in    = op_ff;
                     state_in = S_POP_B;
                  end
               end
            end
         end

         S_POP_B: begin
            ram_rd_en = 1'b1;
            state_in  = S_POP_A;
         end

         S_POP_A: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_m2[AW-1:0];
            b_in        = ram_rd_data;
            state_in    = S_EXEC;
         end

         S_EXEC: begin
            op_in = OP_NONE;
            add_x = {1'b0, ram_rd_data};
            case (op_ff) inside
               OP_ADD, OP_SUB: begin
                  if (op_ff == OP_SUB) begin
                     add_y   = {1'b0, ~b_ff};
                     add_cin = 1'b1;
                  end
                  res_in   = add_sum[DATA_W-1:0];
                  state_in = S_WRITE;
               end
               OP_MUL: begin
                  a_in     = ram_rd_data;
                  q_in     = b_ff;
                  res_in   = '0;
                  iter_in  = '0;
                  state_in = S_MUL_LOOP;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     err_in   = ST_DIVZERO;
                     cnt_in   = cnt_m2;
                     state_in = after_op;
                  end else begin
                     a_in     = ram_rd_data;
                     neg_in   = ram_rd_data[DATA_W-1] ^ b_ff[DATA_W-1];
                     state_in = S_NEG_A;
                  end
               end
               default: begin
                  // unknown operator token just drops both operands
                  cnt_in   = cnt_m2;
                  state_in = after_op;
               end
            endcase
         end

         S_MUL_LOOP: begin
            add_x    = {1'b0, res_ff};
            add_y    = q_ff[0] ? {1'b0, a_ff} : '0;
            res_in   = add_sum[DATA_W-1:0];
            a_in     = a_ff << 1;
            q_in     = q_ff >> 1;
            iter_in  = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               state_in = S_WRITE;
            end
         end

         S_NEG_A: begin
            add_x    = '0;
            add_y    = {1'b1, ~a_ff};
            add_cin  = 1'b1;
            q_in     = a_ff[DATA_W-1] ? add_sum[DATA_W-1:0] : a_ff;
            res_in   = '0;
            state_in = S_NEG_B;
         end

         S_NEG_B: begin
            add_x    = '0;
            add_y    = {1'b1, ~b_ff};
            add_cin  = 1'b1;
            b_in     = b_ff[DATA_W-1] ? add_sum[DATA_W-1:0] : b_ff;
            iter_in  = '0;
            state_in = S_DIV_LOOP;
         end

         S_DIV_LOOP: begin
            // restoring step: carry out means the trial subtract did not borrow
            add_x    = div_shift;
            add_y    = ~{1'b0, b_ff};
            add_cin  = 1'b1;
            res_in   = add_sum[DATA_W+1] ? add_sum[DATA_W-1:0] : div_shift[DATA_W-1:0];
            q_in     = {q_ff[DATA_W-2:0], add_sum[DATA_W+1]};
            iter_in  = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) begin
               state_in = S_DIV_FIX;
            end
         end

         S_DIV_FIX: begin
            add_x    = '0;
            add_y    = {1'b1, ~q_ff};
            add_cin  = 1'b1;
            res_in   = neg_ff ? add_sum[DATA_W-1:0] : q_ff;
            state_in = S_WRITE;
         end

         S_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_m2[AW-1:0];
            ram_wr_data = res_ff;
            cnt_in      = cnt_m1;
            state_in    = after_op;
         end

         S_FINISH: begin
            ram_rd_en = 1'b1;
            if ((err_ff == ST_OK) && (cnt_ff == '0)) begin
               err_in = ST_UNDER;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (err_ff == ST_OK) ? ram_rd_data : '0;
               rsp_status_in = err_ff;
               cnt_in        = '0;
               err_in        = ST_OK;
               last_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   `CHECK_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(STACK_DEPTH),
      "stack count beyond depth")
   `CHECK_IMPL(a_err_value_zero, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK),
      rsp_value_ff == '0, "nonzero value with error status")
   `CHECK_NEXT(a_clean_after_emit, clock, reset, (state_ff == S_EMIT) && out_free,
      (cnt_ff == '0) && (err_ff == ST_OK) && (phase_ff == PH_OUT), "state not cleared")
   `CHECK_NEXT(a_divisor_nonzero, clock, reset, state_ff == S_NEG_B, b_ff != '0,
      "zero divisor entered division loop")

endmodule

// File: design/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/sv/postfix_expression_evaluator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_checker
// Watches both channels of the evaluator, runs its own stack machine on every
// accepted byte and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_checker #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_expr,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_value,
   input  logic [2:0]  rsp_status,
   output int          mismatches,
   output int          results_due
);
   import pfe_pkg::*;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
   } expr_result_t;

   expr_result_t expr_result_q[$];

   logic [31:0] operand_mem [STACK_DEPTH];
   int unsigned operand_cnt;
   logic [31:0] literal_acc;
   phase_type   token_state;
   logic        digits_done;
   op_type      op_held;
   status_type  first_err;
   int          fail_total;

   initial begin
      mismatches  = 0;
      results_due = 0;
      fail_total  = 0;
   end

   function automatic logic blank_byte(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic numeral_byte(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic op_type operator_of(input logic [7:0] c);
      op_type op;
      case (c)
         "+":     op = OP_ADD;
         "-":     op = OP_SUB;
         "*":     op = OP_MUL;
         "/":     op = OP_DIV;
         default: op = OP_OTHER;
      endcase
      return op;
   endfunction

   // signed quotient on magnitudes, most negative by minus one wraps
   function automatic logic [31:0] quotient_toward_zero(input logic [31:0] a,
                                                        input logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? (32'd0 - a) : a;
      mb = b[31] ? (32'd0 - b) : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? (32'd0 - q) : q;
   endfunction

   task push_operand(input logic [31:0] v);
      if (operand_cnt >= STACK_DEPTH) begin
         first_err = ST_OVER;
      end else begin
         operand_mem[operand_cnt] = v;
         operand_cnt++;
      end
   endtask

   task clear_token();
      token_state = PH_OUT;
      literal_acc = 32'd0;
      digits_done = 1'b0;
      op_held     = OP_NONE;
   endtask

   task close_token();
      logic [31:0] a;
      logic [31:0] b;
      if (first_err == ST_OK) begin
         if (token_state == PH_NUM) begin
            push_operand(literal_acc);
         end else if (token_state == PH_OTHER) begin
            if (operand_cnt < 2) begin
               first_err = ST_UNDER;
            end else begin
               b = operand_mem[operand_cnt-1];
               a = operand_mem[operand_cnt-2];
               operand_cnt -= 2;
               case (op_held)
                  OP_ADD: push_operand(a + b);
                  OP_SUB: push_operand(a - b);
                  OP_MUL: push_operand(a * b);
                  OP_DIV: begin
                     if (b == 32'd0) first_err = ST_DIVZERO;
                     else push_operand(quotient_toward_zero(a, b));
                  end
                  default: ;  // unknown token only drops its operands
               endcase
            end
         end
      end
      clear_token();
   endtask

   task take_char(input logic [7:0] c);
      logic [31:0] d;
      d = {24'd0, c} - 32'h30;
      if (blank_byte(c)) begin
         close_token();
      end else if (first_err == ST_OK) begin
         if (token_state == PH_OUT) begin
            if (numeral_byte(c)) begin
               token_state = PH_NUM;
               literal_acc = d;
            end else begin
               token_state = PH_OTHER;
               op_held     = operator_of(c);
            end
         end else if (token_state == PH_NUM) begin
            if (!numeral_byte(c)) begin
               digits_done = 1'b1;
            end else if (!digits_done) begin
               if (literal_acc > 32'd214748364 ||
                   (literal_acc == 32'd214748364 && d > 32'd7)) begin
                  first_err = ST_BIGLIT;
               end else begin
                  literal_acc = literal_acc * 32'd10 + d;
               end
            end
         end else begin
            op_held = OP_OTHER;
         end
      end
   endtask

   task finish_expression(output expr_result_t r);
      close_token();
      r.value  = 32'd0;
      r.status = first_err;
      if (first_err == ST_OK) begin
         if (operand_cnt == 0) r.status = ST_UNDER;
         else r.value = operand_mem[operand_cnt-1];
      end
      operand_cnt = 0;
      first_err   = ST_OK;
      clear_token();
   endtask

   always @(posedge clock) begin : watch_channels
      expr_result_t want;
      if (reset) begin
         operand_cnt = 0;
         first_err   = ST_OK;
         clear_token();
         expr_result_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expr_result_q.size() == 0) begin
               $display("%0t: result transfer with none predicted, actual value %0d status %0d",
                        $time, $signed(rsp_value), rsp_status);
               fail_total++;
            end else begin
               want = expr_result_q.pop_front();
               if (rsp_value !== want.value) begin
                  $display("%0t: rsp_value expected %0d actual %0d",
                           $time, $signed(want.value), $signed(rsp_value));
                  fail_total++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: rsp_status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            take_char(req_in_byte);
            if (req_end_of_expr) begin
               finish_expression(want);
               expr_result_q.push_back(want);
            end
         end
      end
      mismatches  <= fail_total;
      results_due <= expr_result_q.size();
   end

endmodule

// File: tb/sv/postfix_expression_evaluator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top_tb
// Feeds directed and random postfix expressions byte by byte with random gaps
// and result-side stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top_tb;
   import pfe_pkg::*;

   localparam int RANDOM_BYTES = 750;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 100;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte     = 8'h00;
   logic        req_end_of_expr = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic [2:0]  rsp_status;

   int          mismatches;
   int          results_due;
   int          cycle_cnt       = 0;
   int          bytes_sent      = 0;
   bit          quiet           = 1'b0;
   int          stall_hold      = 0;
   logic [7:0]  expr_bytes[$];

   postfix_expression_evaluator_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_expr (req_end_of_expr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status)
   );

   postfix_expression_evaluator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_expr (req_end_of_expr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status),
      .mismatches      (mismatches),
      .results_due     (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("postfix_expression_evaluator_top_tb NOT OK");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // result side alternates stall runs and free runs
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold = $urandom_range(30, 0);
      end else begin
         stall_hold = gap_len();
         rsp_stall <= (stall_hold != 0);
      end
   end

   task put_text(input string s);
      for (int i = 0; i < s.len(); i++) expr_bytes.push_back(s[i]);
   endtask

   task put_byte(input logic [7:0] b);
      expr_bytes.push_back(b);
   endtask

   task put_blank();
      int r;
      r = $urandom_range(9, 0);
      if (r < 7) put_byte(8'h20);
      else if (r < 9) put_byte(8'h09 + 8'($urandom_range(4, 0)));
      else begin
         put_byte(8'h20);
         put_byte(8'h0d);
      end
   endtask

   task put_literal();
      int r;
      longint unsigned v;
      string s;
      r = $urandom_range(99, 0);
      if (r < 55) v = 64'($urandom_range(9, 0));
      else if (r < 75) v = 64'($urandom_range(999, 0));
      else if (r < 88) v = 64'($urandom_range(32'h7fffffff, 0));
      else if (r < 93) v = ($urandom_range(1, 0) != 0) ? 64'd2147483647 : 64'd0;
      else v = 64'd2147483648 + 64'($urandom);
      s = $sformatf("%0d", v);
      if ($urandom_range(9, 0) == 0) s = {"00", s};
      // trailing junk after the digits is dropped by the block
      if ($urandom_range(19, 0) == 0) s = {s, "q7"};
      put_text(s);
   endtask

   // returns by how much the token lowers the stack depth
   task put_operator(output int popped);
      string ops;
      ops = "+-*/";
      put_byte(ops[$urandom_range(3, 0)]);
      popped = 1;
      if ($urandom_range(19, 0) == 0) begin
         put_byte("x");
         popped = 2;
      end
   endtask

   task build_random_expr();
      int kind;
      int depth;
      int pushes_left;
      int popped;
      bit stack_up;
      kind = $urandom_range(99, 0);
      if (kind < 75) begin
         pushes_left = ($urandom_range(19, 0) == 0) ? $urandom_range(18, 14)
                                                    : $urandom_range(6, 1);
         stack_up = ($urandom_range(9, 0) == 0);
         depth = 0;
         while (pushes_left > 0 || depth > 1) begin
            if (depth >= 2 && (pushes_left == 0 ||
                (!stack_up && $urandom_range(2, 0) == 0))) begin
               put_operator(popped);
               depth -= popped;
            end else begin
               put_literal();
               depth++;
               pushes_left--;
            end
            if (pushes_left > 0 || depth > 1) put_blank();
         end
      end else if (kind < 87) begin
         repeat ($urandom_range(10, 1)) begin
            if ($urandom_range(3, 0) == 0) put_blank();
            else put_byte(8'($urandom_range(255, 0)));
         end
      end else begin
         repeat ($urandom_range(6, 1)) begin
            if ($urandom_range(1, 0) != 0) put_literal();
            else put_operator(popped);
            put_blank();
         end
      end
      if ($urandom_range(1, 0) != 0) put_blank();
   endtask

   task send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = quiet ? 0 : gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_end_of_expr <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task send_expr();
      for (int i = 0; i < expr_bytes.size(); i++) begin
         send_byte(expr_bytes[i], i == expr_bytes.size() - 1);
      end
      bytes_sent += expr_bytes.size();
      expr_bytes.delete();
   endtask

   task send_text(input string s);
      put_text(s);
      send_expr();
   endtask

   task wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task run_directed();
      send_text("2147483647 1 +");
      send_text("00002147483647");
      send_text("2147483648");
      send_text("99999999999 1 +");
      send_text("0 2147483647 - 1 - 0 1 - /");
      send_text("0 7 - 2 /");
      send_text("7 0 /");
      // first error is kept over the later big literal
      send_text("1 0 / 2147483648 +");
      send_text("+");
      send_text("1 +");
      send_text("6 7 *");
      send_text("9 4 -");
      send_text("65536 65536 *");
      send_text("1 3 4 +x");
      send_text("3 4 +x");
      send_text("12ab 3 +");
      send_text("12a3");
      send_text(" ");
      // tab, line feed, vertical tab, form feed and carriage return as separators, ending on carriage return
      put_byte(8'h09);
      put_text("5");
      put_byte(8'h0a);
      put_text("6");
      put_byte(8'h0b);
      put_text("+");
      put_byte(8'h0c);
      put_byte(8'h0d);
      send_expr();
      put_text("1 2 ");
      put_byte(8'h00);
      send_expr();
      put_text("3 5 ");
      put_byte(8'hff);
      put_byte(8'h80);
      put_text(" 7");
      send_expr();
      repeat (17) put_text("1 ");
      send_expr();
   endtask

   initial begin
      bit drained;
      drained = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(7, 0) == 0) quiet = !quiet;
         if (!drained && bytes_sent > RANDOM_BYTES / 2) begin
            wait_results();
            drained = 1'b1;
         end
         build_random_expr();
         send_expr();
      end
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("postfix_expression_evaluator_top_tb OK");
      end else begin
         $display("postfix_expression_evaluator_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: postfix_expression_evaluator_top.f
+incdir+design
design/pfe_pkg.sv
design/pfe_ram.sv
design/postfix_expression_evaluator_top.sv
tb/sv/postfix_expression_evaluator_checker.sv
tb/sv/postfix_expression_evaluator_top_tb.sv
